>>> rtl/owids_pkg.sv
// Shared types and constants for the 1-Wire identity search slave.
// Used by the configuration registers, the line controller, the output skid
// buffer and the top level. No dependencies.
`default_nettype none

package owids_pkg;

  // Configuration port geometry.
  localparam int unsigned CFG_DATA_BITS = 64;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned LEN_BITS      = 10;
  localparam int unsigned CMD_BITS      = 8;

  // Default values for the top-level parameters.
  localparam int unsigned ID_BITS_DEFAULT    = 64;
  localparam int unsigned COUNT_BITS_DEFAULT = 10;

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned IN_DATA_BITS  = 8;
  localparam int unsigned OUT_DATA_BITS = 16;

  // Register reset values.
  localparam logic [CFG_DATA_BITS-1:0] ROM_ID_RESET = 64'd10232178472644805889;
  localparam logic [LEN_BITS-1:0] RESET_MIN_RESET  = 10'd200;
  localparam logic [LEN_BITS-1:0] ONE_MAX_RESET    = 10'd40;
  localparam logic [LEN_BITS-1:0] PRES_WAIT_RESET  = 10'd50;
  localparam logic [LEN_BITS-1:0] PRES_LEN_RESET   = 10'd150;
  localparam logic [LEN_BITS-1:0] PRES_REC_RESET   = 10'd150;
  localparam logic [LEN_BITS-1:0] ZERO_LEN_RESET   = 10'd35;
  localparam logic [CMD_BITS-1:0] SEARCH_CMD_RESET = 8'hF0;

  // Fixed slot timings in ticks.
  localparam int unsigned GUARD_TICKS = 5;
  localparam int unsigned HOLD_TICKS  = 10;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ROM_ID     = 3'd0,
    REG_RESET_MIN  = 3'd1,
    REG_ONE_MAX    = 3'd2,
    REG_PRES_WAIT  = 3'd3,
    REG_PRES_LEN   = 3'd4,
    REG_PRES_REC   = 3'd5,
    REG_ZERO_LEN   = 3'd6,
    REG_SEARCH_CMD = 3'd7
  } cfg_reg_e;

  // Bus protocol phases.
  typedef enum logic [3:0] {
    PH_HUNT_IDLE,
    PH_HUNT_LOW,
    PH_PRES_WAIT,
    PH_PRES_DRIVE,
    PH_PRES_RECOVER,
    PH_CMD_IDLE,
    PH_CMD_LOW,
    PH_TX_IDLE,
    PH_TX_DRIVE,
    PH_TX_GUARD,
    PH_TX_HOLD,
    PH_DIR_IDLE,
    PH_DIR_LOW
  } phase_e;

  // Which of the three slots of a search bit is under way.
  typedef enum logic [1:0] {
    SLOT_BIT,
    SLOT_COMP,
    SLOT_DIR
  } slot_e;

  // Timing and command registers.
  typedef struct packed {
    logic [LEN_BITS-1:0] reset_min_ticks;
    logic [LEN_BITS-1:0] one_max_ticks;
    logic [LEN_BITS-1:0] presence_wait;
    logic [LEN_BITS-1:0] presence_len;
    logic [LEN_BITS-1:0] presence_recover;
    logic [LEN_BITS-1:0] zero_len;
    logic [CMD_BITS-1:0] search_command;
  } cfg_t;

  // One result per tick.
  typedef struct packed {
    logic [CMD_BITS-1:0] command_byte;
    logic                command_done;
    logic                drive_low;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/owids_cfg_regs.sv
// Configuration register file of the 1-Wire identity search slave.
// Depends on owids_pkg for register indexes, widths and reset values.
`default_nettype none

module owids_cfg_regs #(
  parameter int unsigned ID_BITS = owids_pkg::ID_BITS_DEFAULT
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_we_i,
  input  wire logic [owids_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  wire logic [owids_pkg::CFG_DATA_BITS-1:0]    cfg_wdata_i,
  output owids_pkg::cfg_t                             cfg_o,
  output logic [ID_BITS-1:0]                          rom_id_o
);

  owids_pkg::cfg_t     cfg_q;
  logic [ID_BITS-1:0]  rom_id_q;

  // Register writes; every index names a register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_id_q               <= owids_pkg::ROM_ID_RESET[ID_BITS-1:0];
      cfg_q.reset_min_ticks  <= owids_pkg::RESET_MIN_RESET;
      cfg_q.one_max_ticks    <= owids_pkg::ONE_MAX_RESET;
      cfg_q.presence_wait    <= owids_pkg::PRES_WAIT_RESET;
      cfg_q.presence_len     <= owids_pkg::PRES_LEN_RESET;
      cfg_q.presence_recover <= owids_pkg::PRES_REC_RESET;
      cfg_q.zero_len         <= owids_pkg::ZERO_LEN_RESET;
      cfg_q.search_command   <= owids_pkg::SEARCH_CMD_RESET;
    end else if (cfg_we_i) begin
      unique case (owids_pkg::cfg_reg_e'(cfg_index_i))
        owids_pkg::REG_ROM_ID:     rom_id_q <= cfg_wdata_i[ID_BITS-1:0];
        owids_pkg::REG_RESET_MIN:
          cfg_q.reset_min_ticks <= cfg_wdata_i[owids_pkg::LEN_BITS-1:0];
        owids_pkg::REG_ONE_MAX:
          cfg_q.one_max_ticks <= cfg_wdata_i[owids_pkg::LEN_BITS-1:0];
        owids_pkg::REG_PRES_WAIT:
          cfg_q.presence_wait <= cfg_wdata_i[owids_pkg::LEN_BITS-1:0];
        owids_pkg::REG_PRES_LEN:
          cfg_q.presence_len <= cfg_wdata_i[owids_pkg::LEN_BITS-1:0];
        owids_pkg::REG_PRES_REC:
          cfg_q.presence_recover <= cfg_wdata_i[owids_pkg::LEN_BITS-1:0];
        owids_pkg::REG_ZERO_LEN:
          cfg_q.zero_len <= cfg_wdata_i[owids_pkg::LEN_BITS-1:0];
        owids_pkg::REG_SEARCH_CMD:
          cfg_q.search_command <= cfg_wdata_i[owids_pkg::CMD_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o    = cfg_q;
  assign rom_id_o = rom_id_q;

endmodule

`default_nettype wire

>>> rtl/owids_core.sv
// Tick-by-tick bus controller: reset hunt, presence, command read, ID search.
// Depends on owids_pkg for the phase and slot types and the register struct.
`default_nettype none

module owids_core #(
  parameter int unsigned ID_BITS    = owids_pkg::ID_BITS_DEFAULT,
  parameter int unsigned COUNT_BITS = owids_pkg::COUNT_BITS_DEFAULT
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                acc_i,
  input  wire logic                line_level_i,
  input  owids_pkg::cfg_t          cfg_i,
  input  wire logic [ID_BITS-1:0]  rom_id_i,
  output owids_pkg::result_t       res_o
);

  localparam int unsigned IDX_BITS = $clog2(ID_BITS);
  localparam int unsigned CMP_BITS =
    (COUNT_BITS > owids_pkg::LEN_BITS) ? COUNT_BITS : owids_pkg::LEN_BITS;
  localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
  localparam logic [IDX_BITS-1:0]   LAST_BIT = IDX_BITS'(ID_BITS - 1);

  // Length register clamped to what the tick counter can reach.
  function automatic logic [COUNT_BITS-1:0] clamp_len(
    input logic [owids_pkg::LEN_BITS-1:0] v
  );
    logic [CMP_BITS-1:0] ve;
    ve = CMP_BITS'(v);
    if (ve > CMP_BITS'(CNT_MAX)) begin
      return CNT_MAX;
    end
    return ve[COUNT_BITS-1:0];
  endfunction

  function automatic logic is_timed(input owids_pkg::phase_e p);
    return p == owids_pkg::PH_PRES_WAIT || p == owids_pkg::PH_PRES_DRIVE ||
           p == owids_pkg::PH_PRES_RECOVER || p == owids_pkg::PH_TX_DRIVE ||
           p == owids_pkg::PH_TX_GUARD || p == owids_pkg::PH_TX_HOLD;
  endfunction

  // Entering a timed phase of zero length falls straight through to the next.
  function automatic owids_pkg::phase_e skip_zero(
    input owids_pkg::phase_e p,
    input logic wait_z,
    input logic len_z,
    input logic rec_z,
    input logic zero_z
  );
    owids_pkg::phase_e r;
    r = p;
    if (r == owids_pkg::PH_PRES_WAIT && wait_z) begin
      r = owids_pkg::PH_PRES_DRIVE;
    end
    if (r == owids_pkg::PH_PRES_DRIVE && len_z) begin
      r = owids_pkg::PH_PRES_RECOVER;
    end
    if (r == owids_pkg::PH_PRES_RECOVER && rec_z) begin
      r = owids_pkg::PH_CMD_IDLE;
    end
    if (r == owids_pkg::PH_TX_DRIVE && zero_z) begin
      r = owids_pkg::PH_TX_GUARD;
    end
    return r;
  endfunction

  owids_pkg::phase_e     phase_q, phase_d, nxt_ph;
  logic [COUNT_BITS-1:0] tick_q, tick_d, tick_sat, cur_len;
  logic [COUNT_BITS:0]   tick_next;
  logic [IDX_BITS-1:0]   bit_q, bit_d;
  owids_pkg::slot_e      slot_q, slot_d;
  logic [owids_pkg::CMD_BITS-1:0] cmd_q, cmd_d;
  logic                  drive, done, rom_bit, send_zero;
  logic                  wait_z, len_z, rec_z, zero_z;
  logic [COUNT_BITS-1:0] len_wait, len_pres, len_rec, len_zero;

  assign len_wait = clamp_len(cfg_i.presence_wait);
  assign len_pres = clamp_len(cfg_i.presence_len);
  assign len_rec  = clamp_len(cfg_i.presence_recover);
  assign len_zero = clamp_len(cfg_i.zero_len);
  assign wait_z   = (cfg_i.presence_wait == '0);
  assign len_z    = (cfg_i.presence_len == '0);
  assign rec_z    = (cfg_i.presence_recover == '0);
  assign zero_z   = (cfg_i.zero_len == '0);

  assign tick_sat  = (tick_q != CNT_MAX) ? tick_q + COUNT_BITS'(1) : tick_q;
  assign rom_bit   = rom_id_i[bit_q];
  assign send_zero = (slot_q == owids_pkg::SLOT_BIT) ? !rom_bit : rom_bit;

  // Next state for one tick: line event first, then the timed-phase count.
  always_comb begin
    phase_d   = phase_q;
    tick_d    = tick_q;
    bit_d     = bit_q;
    slot_d    = slot_q;
    cmd_d     = cmd_q;
    drive     = 1'b0;
    done      = 1'b0;
    nxt_ph    = phase_q;
    cur_len   = COUNT_BITS'(owids_pkg::HOLD_TICKS);
    tick_next = '0;

    unique case (phase_q)
      owids_pkg::PH_HUNT_IDLE: begin
        if (!line_level_i) begin
          phase_d = owids_pkg::PH_HUNT_LOW;
          tick_d  = COUNT_BITS'(1);
        end
      end
      owids_pkg::PH_CMD_IDLE: begin
        if (!line_level_i) begin
          phase_d = owids_pkg::PH_CMD_LOW;
          tick_d  = COUNT_BITS'(1);
        end
      end
      owids_pkg::PH_HUNT_LOW: begin
        if (!line_level_i) begin
          tick_d = tick_sat;
        end else if (CMP_BITS'(tick_q) > CMP_BITS'(cfg_i.reset_min_ticks)) begin
          cmd_d   = '0;
          bit_d   = '0;
          slot_d  = owids_pkg::SLOT_BIT;
          tick_d  = '0;
          phase_d = skip_zero(owids_pkg::PH_PRES_WAIT, wait_z, len_z, rec_z, zero_z);
        end else begin
          phase_d = owids_pkg::PH_HUNT_IDLE;
        end
      end
      owids_pkg::PH_CMD_LOW: begin
        if (!line_level_i) begin
          tick_d = tick_sat;
        end else begin
          if (CMP_BITS'(tick_q) < CMP_BITS'(cfg_i.one_max_ticks) &&
              tick_q != CNT_MAX) begin
            cmd_d[bit_q[2:0]] = 1'b1;
          end
          if (bit_q[2:0] == 3'd7) begin
            done    = 1'b1;
            bit_d   = '0;
            slot_d  = owids_pkg::SLOT_BIT;
            phase_d = (cmd_d == cfg_i.search_command) ? owids_pkg::PH_TX_IDLE
                                                      : owids_pkg::PH_HUNT_IDLE;
          end else begin
            bit_d   = IDX_BITS'(bit_q[2:0] + 3'd1);
            phase_d = owids_pkg::PH_CMD_IDLE;
          end
          tick_d = '0;
        end
      end
      owids_pkg::PH_TX_IDLE: begin
        if (!line_level_i) begin
          tick_d  = '0;
          phase_d = skip_zero(send_zero ? owids_pkg::PH_TX_DRIVE : owids_pkg::PH_TX_HOLD,
                              wait_z, len_z, rec_z, zero_z);
        end
      end
      owids_pkg::PH_DIR_IDLE: begin
        if (!line_level_i) begin
          phase_d = owids_pkg::PH_DIR_LOW;
        end
      end
      owids_pkg::PH_DIR_LOW: begin
        if (line_level_i) begin
          slot_d = owids_pkg::SLOT_BIT;
          if (bit_q == LAST_BIT) begin
            bit_d   = '0;
            phase_d = owids_pkg::PH_HUNT_IDLE;
          end else begin
            bit_d   = bit_q + IDX_BITS'(1);
            phase_d = owids_pkg::PH_TX_IDLE;
          end
        end
      end
      default: ;
    endcase

    // A presence skipped entirely lands in the command read with a fresh index.
    if (phase_d == owids_pkg::PH_CMD_IDLE && phase_q != owids_pkg::PH_CMD_IDLE &&
        phase_q != owids_pkg::PH_CMD_LOW) begin
      bit_d = '0;
    end

    // Timed phases count this tick and move on when their length is reached.
    if (is_timed(phase_d)) begin
      drive = (phase_d == owids_pkg::PH_PRES_DRIVE) ||
              (phase_d == owids_pkg::PH_TX_DRIVE);
      unique case (phase_d)
        owids_pkg::PH_PRES_WAIT:    cur_len = len_wait;
        owids_pkg::PH_PRES_DRIVE:   cur_len = len_pres;
        owids_pkg::PH_PRES_RECOVER: cur_len = len_rec;
        owids_pkg::PH_TX_DRIVE:     cur_len = len_zero;
        owids_pkg::PH_TX_GUARD:     cur_len = COUNT_BITS'(owids_pkg::GUARD_TICKS);
        default:                    cur_len = COUNT_BITS'(owids_pkg::HOLD_TICKS);
      endcase
      tick_next = {1'b0, tick_d} + (COUNT_BITS + 1)'(1);
      if (tick_next >= {1'b0, cur_len}) begin
        unique case (phase_d)
          owids_pkg::PH_PRES_WAIT:    nxt_ph = owids_pkg::PH_PRES_DRIVE;
          owids_pkg::PH_PRES_DRIVE:   nxt_ph = owids_pkg::PH_PRES_RECOVER;
          owids_pkg::PH_PRES_RECOVER: nxt_ph = owids_pkg::PH_CMD_IDLE;
          owids_pkg::PH_TX_DRIVE:     nxt_ph = owids_pkg::PH_TX_GUARD;
          default: begin
            if (slot_d == owids_pkg::SLOT_BIT) begin
              slot_d = owids_pkg::SLOT_COMP;
              nxt_ph = owids_pkg::PH_TX_IDLE;
            end else begin
              slot_d = owids_pkg::SLOT_DIR;
              nxt_ph = owids_pkg::PH_DIR_IDLE;
            end
          end
        endcase
        phase_d = skip_zero(nxt_ph, wait_z, len_z, rec_z, zero_z);
        if (phase_d == owids_pkg::PH_CMD_IDLE) begin
          bit_d = '0;
        end
        tick_d = '0;
      end else begin
        tick_d = tick_next[COUNT_BITS-1:0];
      end
    end
  end

  // State advances once per accepted tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= owids_pkg::PH_HUNT_IDLE;
      tick_q  <= '0;
      bit_q   <= '0;
      slot_q  <= owids_pkg::SLOT_BIT;
      cmd_q   <= '0;
    end else if (acc_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      slot_q  <= slot_d;
      cmd_q   <= cmd_d;
    end
  end

  assign res_o.drive_low    = drive;
  assign res_o.command_done = done;
  assign res_o.command_byte = cmd_d;

  // A finished command leads either to the search or back to the reset hunt.
  a_done_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i && res_o.command_done) |=>
      (phase_q == owids_pkg::PH_TX_IDLE || phase_q == owids_pkg::PH_HUNT_IDLE))
    else $error("command end did not lead to search or hunt");

  // The bit index stays inside the identity.
  a_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(bit_q) < ID_BITS)
    else $error("bit index beyond identity");

  // During the command read the index counts command bits only.
  a_cmd_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == owids_pkg::PH_CMD_IDLE || phase_q == owids_pkg::PH_CMD_LOW) |->
      int'(bit_q) < 8)
    else $error("command bit index out of range");

  // The direction slot is only entered after both answer slots.
  a_dir_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == owids_pkg::PH_DIR_IDLE || phase_q == owids_pkg::PH_DIR_LOW) |->
      slot_q == owids_pkg::SLOT_DIR)
    else $error("direction phase without direction slot");

endmodule

`default_nettype wire

>>> rtl/owids_skid.sv
// Output register with one skid entry for the result stream.
// Depends on owids_pkg for the result struct.
`default_nettype none

module owids_skid (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  owids_pkg::result_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output owids_pkg::result_t out_data_o
);

  logic               out_valid_q, skid_valid_q;
  owids_pkg::result_t out_data_q, skid_data_q;
  logic               in_acc, out_free;

  assign in_ready_o = !skid_valid_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Control: the skid entry fills only while the output register is stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || in_acc;
      skid_valid_q <= 1'b0;
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_data_q <= skid_valid_q ? skid_data_q : in_data_i;
    end else if (in_acc) begin
      skid_data_q <= in_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

>>> rtl/one_wire_id_slave_search.sv
// 1-Wire serial-number slave that answers the identity search.
// Each input transaction carries one microsecond sample of the bus level in
// s_axis_tdata_i bit 0; each accepted sample yields exactly one output
// transaction saying whether to pull the bus low during that tick, together
// with the command-complete flag and the command byte received so far.
// Throughput is one sample per clock cycle while s_axis_tready_o is high;
// the whole protocol step for a tick is worked out in the cycle in which
// the sample is accepted, and the result is registered in the output stage.
// The output side has one register and one skid entry: if the receiver
// stalls, one further sample is still taken, after which s_axis_tready_o
// drops until the output register drains.
// Registers are written through cfg_we_i / cfg_index_i / cfg_wdata_i with no
// wait states; the user writes only while the stream is idle; not enforced.
// Reset restores the register defaults, clears the stream and puts the
// controller in the reset hunt, waiting for a long low pulse on the bus.
// Depends on owids_pkg, owids_cfg_regs, owids_core and owids_skid.
`default_nettype none

module one_wire_id_slave_search #(
  parameter int unsigned ID_BITS    = owids_pkg::ID_BITS_DEFAULT,
  parameter int unsigned COUNT_BITS = owids_pkg::COUNT_BITS_DEFAULT
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // Input stream.
  input  wire logic                                  s_axis_tvalid_i,
  output logic                                       s_axis_tready_o,
  // Fields from bit 0: line_level, zero padding.
  input  wire logic [owids_pkg::IN_DATA_BITS-1:0]    s_axis_tdata_i,
  // Output stream.
  output logic                                       m_axis_tvalid_o,
  input  wire logic                                  m_axis_tready_i,
  // Fields from bit 0: drive_low, command_done, command_byte, zero padding.
  output logic [owids_pkg::OUT_DATA_BITS-1:0]        m_axis_tdata_o,
  // Configuration write port.
  input  wire logic                                  cfg_we_i,
  input  wire logic [owids_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  wire logic [owids_pkg::CFG_DATA_BITS-1:0]   cfg_wdata_i
);

  owids_pkg::cfg_t     cfg;
  logic [ID_BITS-1:0]  rom_id;
  owids_pkg::result_t  core_res, out_res;
  logic                in_acc;

  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  // Register file.
  owids_cfg_regs #(
    .ID_BITS (ID_BITS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .rom_id_o    (rom_id)
  );

  // Protocol controller.
  owids_core #(
    .ID_BITS    (ID_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (in_acc),
    .line_level_i (s_axis_tdata_i[0]),
    .cfg_i        (cfg),
    .rom_id_i     (rom_id),
    .res_o        (core_res)
  );

  // Result buffering.
  owids_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_data_i   (core_res),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (out_res)
  );

  // Pack the result fields into the output data word.
  assign m_axis_tdata_o = {
    (owids_pkg::OUT_DATA_BITS - owids_pkg::CMD_BITS - 2)'(0),
    out_res.command_byte,
    out_res.command_done,
    out_res.drive_low
  };

endmodule

`default_nettype wire
